// ===== src/dpdp_pkg.sv =====
// ----------------------------------------------------------------------------
// DMA page descriptor pool - shared definitions
// Table size, command and status codes, request and response layouts.
// ----------------------------------------------------------------------------
package dpdp_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int GRP     = 8;
    localparam int NGRP    = (ENTRIES + GRP - 1) / GRP;
    localparam int PAD_W   = NGRP * GRP;
    localparam int GCNT_W  = $clog2(GRP + 1);

    localparam logic [2:0] CMD_WRITE_LOW  = 3'd0;
    localparam logic [2:0] CMD_WRITE_HIGH = 3'd1;
    localparam logic [2:0] CMD_ALLOC      = 3'd2;
    localparam logic [2:0] CMD_FREE       = 3'd3;
    localparam logic [2:0] CMD_READ       = 3'd4;
    localparam logic [2:0] CMD_RESET_ALL  = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NONE_FREE = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [5:0]  index;
        logic [63:0] host_addr;
        logic [31:0] bus_addr_low;
        logic [31:0] bus_addr_high;
        logic [63:0] free_handle;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  slot;
        logic [63:0] host_addr_out;
        logic [31:0] bus_low_out;
        logic [31:0] bus_high_out;
        logic [63:0] handle_out;
        logic [6:0]  free_count;
    } t_rsp;

    typedef struct packed {
        logic [63:0] host_addr;
        logic [31:0] bus_low;
        logic [63:0] handle;
    } t_lo_word;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] slot;
        logic       rd_lo;
        logic       rd_hi;
    } t_stage_ctl;

endpackage

// ===== src/dma_page_descriptor_pool.sv =====
// ----------------------------------------------------------------------------
// DMA page descriptor pool
// First-fit pool of page descriptors held in two synchronous memories.
//
// Requests enter on i_req with i_req_valid / o_req_stall; one response per
// request leaves on o_rsp with o_rsp_valid / i_rsp_stall, in request order.
// A request is accepted when i_req_valid is high and o_req_stall is low.
// A response passes stage one, stage two and the response register in turn.
// Throughput: one request per cycle while o_req_stall is low. Busy marks and
// populated marks live in flip-flops and are updated at the accepting edge;
// the descriptor fields live in two memories read at that edge. The free
// count is taken through a two-stage registered count tree over the busy and
// populated marks. Reset clears the busy, populated and written marks; no
// clearing pass runs, and never-written descriptors read as zero.
// When the receiver stalls, the response register holds, the two inner
// stages fill, and o_req_stall rises until the response is taken.
// ----------------------------------------------------------------------------
module dma_page_descriptor_pool
    import dpdp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_stall,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_stall,
    output t_rsp o_rsp
);

    logic [ENTRIES-1:0] r_busy, n_busy;
    logic [ENTRIES-1:0] r_nz, n_nz;
    logic [ENTRIES-1:0] r_vlo, n_vlo;
    logic [ENTRIES-1:0] r_vhi, n_vhi;

    logic       r_s1_valid, r_s2_valid, r_rsp_valid;
    t_stage_ctl r_s1_ctl, n_s1_ctl, r_s2_ctl;
    t_lo_word   r_rd_lo, r_s2_lo;
    logic [31:0] r_rd_hi, r_s2_hi;
    logic [GCNT_W-1:0] r_s2_gcnt [NGRP];
    t_rsp       r_rsp;

    t_lo_word    mem_lo [ENTRIES];
    logic [31:0] mem_hi [ENTRIES];

    logic             adv_out, s2_free, s1_free, acc;
    logic             ok_idx;
    logic [IDX_W-1:0] addr;
    logic [ENTRIES-1:0] cand;
    logic             cand_any;
    logic [IDX_W-1:0] sel;
    logic             grant_ok;
    logic [CNT_W-1:0] first_zero;
    logic [PAD_W-1:0] avail;
    logic [CNT_W-1:0] sum;
    logic [6:0]       free_sat;

    assign adv_out     = !r_rsp_valid || !i_rsp_stall;
    assign s2_free     = !r_s2_valid || adv_out;
    assign s1_free     = !r_s1_valid || s2_free;
    assign acc         = i_req_valid && s1_free;
    assign o_req_stall = !s1_free;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    assign ok_idx = (32'(i_req.index) < ENTRIES);
    assign addr   = IDX_W'(i_req.index);

    // first-fit: lowest entry that is either unpopulated or idle
    assign cand = ~r_nz | ~r_busy;

    always_comb begin
        cand_any = 1'b0;
        sel      = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (cand[i]) begin
                cand_any = 1'b1;
                sel      = IDX_W'(i);
            end
        end
    end

    assign grant_ok = cand_any && r_nz[sel] && !r_busy[sel];

    always_comb begin
        n_busy = r_busy;
        n_nz   = r_nz;
        n_vlo  = r_vlo;
        n_vhi  = r_vhi;
        n_s1_ctl.status = ST_OK;
        n_s1_ctl.slot   = i_req.index;
        n_s1_ctl.rd_lo  = 1'b0;
        n_s1_ctl.rd_hi  = 1'b0;
        unique case (i_req.cmd)
            CMD_WRITE_LOW: begin
                if (ok_idx) begin
                    n_nz[addr]  = (i_req.host_addr != '0);
                    n_vlo[addr] = 1'b1;
                end
            end
            CMD_WRITE_HIGH: begin
                if (ok_idx) begin
                    n_vhi[addr] = 1'b1;
                end
            end
            CMD_ALLOC: begin
                if (grant_ok) begin
                    n_busy[sel]   = 1'b1;
                    n_s1_ctl.slot = 6'(sel);
                end else begin
                    n_s1_ctl.status = ST_NONE_FREE;
                    n_s1_ctl.slot   = '0;
                end
            end
            CMD_FREE: begin
                if (ok_idx) begin
                    n_busy[addr] = 1'b0;
                end
            end
            CMD_READ: begin
                n_s1_ctl.rd_lo = ok_idx && r_vlo[addr];
                n_s1_ctl.rd_hi = ok_idx && r_vhi[addr];
            end
            CMD_RESET_ALL: begin
                n_busy = '0;
            end
            default: begin
                n_s1_ctl.status = ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
            r_nz   <= '0;
            r_vlo  <= '0;
            r_vhi  <= '0;
        end else if (acc) begin
            r_busy <= n_busy;
            r_nz   <= n_nz;
            r_vlo  <= n_vlo;
            r_vhi  <= n_vhi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            if ((i_req.cmd == CMD_WRITE_LOW) && ok_idx) begin
                mem_lo[addr] <= '{host_addr: i_req.host_addr,
                                  bus_low:   i_req.bus_addr_low,
                                  handle:    i_req.free_handle};
            end
            r_rd_lo <= mem_lo[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            if ((i_req.cmd == CMD_WRITE_HIGH) && ok_idx) begin
                mem_hi[addr] <= i_req.bus_addr_high;
            end
            r_rd_hi <= mem_hi[addr];
        end
    end

    // populated entries lie below the first entry with a zero host address
    always_comb begin
        first_zero = CNT_W'(ENTRIES);
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_nz[i]) begin
                first_zero = CNT_W'(i);
            end
        end
        avail = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            avail[i] = (CNT_W'(i) < first_zero) && !r_busy[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= acc;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (adv_out) begin
                r_rsp_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_ctl <= n_s1_ctl;
        end
        if (r_s1_valid && s2_free) begin
            r_s2_ctl <= r_s1_ctl;
            r_s2_lo  <= r_s1_ctl.rd_lo ? r_rd_lo : '0;
            r_s2_hi  <= r_s1_ctl.rd_hi ? r_rd_hi : '0;
            for (int g = 0; g < NGRP; g++) begin
                r_s2_gcnt[g] <= GCNT_W'($countones(avail[g*GRP +: GRP]));
            end
        end
        if (r_s2_valid && adv_out) begin
            r_rsp.status        <= r_s2_ctl.status;
            r_rsp.slot          <= r_s2_ctl.slot;
            r_rsp.host_addr_out <= r_s2_lo.host_addr;
            r_rsp.bus_low_out   <= r_s2_lo.bus_low;
            r_rsp.bus_high_out  <= r_s2_hi;
            r_rsp.handle_out    <= r_s2_lo.handle;
            r_rsp.free_count    <= free_sat;
        end
    end

    always_comb begin
        sum = '0;
        for (int g = 0; g < NGRP; g++) begin
            sum = sum + CNT_W'(r_s2_gcnt[g]);
        end
        free_sat = (32'(sum) > 127) ? 7'd127 : 7'(sum);
    end

    a_grant_marks_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_req.cmd == CMD_ALLOC) && grant_ok) |=> r_busy[$past(sel)])
        else $error("granted entry not marked busy");

    a_grant_was_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_req.cmd == CMD_ALLOC) && grant_ok) |-> (r_nz[sel] && !r_busy[sel]))
        else $error("grant of an unpopulated or busy entry");

    a_invalid_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && (r_rsp.status == ST_INVALID)) |->
        ((r_rsp.host_addr_out == '0) && (r_rsp.handle_out == '0)
         && (r_rsp.bus_low_out == '0) && (r_rsp.bus_high_out == '0)))
        else $error("invalid command returned data");

    a_s2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !adv_out) |=> r_s2_valid)
        else $error("stalled stage two lost its request");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid |-> (32'(r_rsp.free_count) <= ENTRIES))
        else $error("free count exceeds table size");

endmodule

// ===== verif/dma_page_descriptor_pool_test.sv =====
// ----------------------------------------------------------------------------
// DMA page descriptor pool - block-level test
// Drives write, alloc, free, read, reset-all and invalid requests through the
// valid/stall request channel and compares every response against a
// first-fit pool predictor. A directed opening is followed by random
// populate-then-operate sequences under four idling phases.
// ----------------------------------------------------------------------------
module dma_page_descriptor_pool_test;
    import dpdp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [2:0] CMD_UNUSED_7 = 3'd7;
    localparam int unsigned REQ_TARGET  = 1275;

    typedef struct {
        t_req        req;
        int unsigned tx_idle_pct;
        int unsigned rx_stall_pct;
        bit          drain_first;
    } t_queued_req;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    logic i_rsp_stall = 1'b0;
    t_req i_req       = '0;
    logic o_req_stall;
    logic o_rsp_valid;
    t_rsp o_rsp;

    t_queued_req pending_req_q[$];
    t_rsp        expected_rsp_q[$];
    t_queued_req staged_req;

    logic [63:0] desc_host   [ENTRIES];
    logic [31:0] desc_low    [ENTRIES];
    logic [31:0] desc_high   [ENTRIES];
    logic [63:0] desc_handle [ENTRIES];
    logic        desc_busy   [ENTRIES];

    int unsigned rst_cycles     = 0;
    int unsigned rx_stall_pct   = 0;
    bit          req_taken      = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned rsp_checked    = 0;
    int unsigned alloc_granted  = 0;
    int unsigned alloc_refused  = 0;
    int unsigned populate_runs  = 0;

    int unsigned gen_tx_idle  = 0;
    int unsigned gen_rx_stall = 0;
    bit          gen_drain    = 1'b0;

    dma_page_descriptor_pool dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_rsp pool_apply(input t_req r);
        t_rsp        rsp;
        int          i;
        int          idx;
        bit          granted;
        int unsigned n_free;
        rsp         = '0;
        rsp.status  = ST_OK;
        rsp.slot    = r.index;
        idx         = int'(r.index);
        granted     = 1'b0;
        n_free      = 0;
        case (r.cmd)
            CMD_WRITE_LOW: begin
                desc_host[idx]   = r.host_addr;
                desc_low[idx]    = r.bus_addr_low;
                desc_handle[idx] = r.free_handle;
            end
            CMD_WRITE_HIGH: begin
                desc_high[idx] = r.bus_addr_high;
            end
            CMD_ALLOC: begin
                rsp.status = ST_NONE_FREE;
                rsp.slot   = '0;
                for (i = 0; i < ENTRIES && desc_host[i] != '0 && !granted; i++) begin
                    if (!desc_busy[i]) begin
                        desc_busy[i] = 1'b1;
                        rsp.status   = ST_OK;
                        rsp.slot     = i[5:0];
                        granted      = 1'b1;
                    end
                end
                if (granted) alloc_granted++;
                else alloc_refused++;
            end
            CMD_FREE: begin
                desc_busy[idx] = 1'b0;
            end
            CMD_READ: begin
                rsp.host_addr_out = desc_host[idx];
                rsp.bus_low_out   = desc_low[idx];
                rsp.bus_high_out  = desc_high[idx];
                rsp.handle_out    = desc_handle[idx];
            end
            CMD_RESET_ALL: begin
                for (i = 0; i < ENTRIES; i++) desc_busy[i] = 1'b0;
            end
            default: begin
                rsp.status = ST_INVALID;
            end
        endcase
        for (i = 0; i < ENTRIES && desc_host[i] != '0; i++) begin
            if (!desc_busy[i]) n_free++;
        end
        rsp.free_count = (n_free > 127) ? 7'd127 : n_free[6:0];
        return rsp;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_response(input t_rsp got);
        t_rsp want;
        if (expected_rsp_q.size() == 0) begin
            $display("%0t ns: response expected none actual %h", $time, got);
            mismatch_count++;
        end else begin
            want = expected_rsp_q.pop_front();
            compare_field("status", 64'(want.status), 64'(got.status));
            compare_field("slot", 64'(want.slot), 64'(got.slot));
            compare_field("host_addr_out", want.host_addr_out, got.host_addr_out);
            compare_field("bus_low_out", 64'(want.bus_low_out), 64'(got.bus_low_out));
            compare_field("bus_high_out", 64'(want.bus_high_out), 64'(got.bus_high_out));
            compare_field("handle_out", want.handle_out, got.handle_out);
            compare_field("free_count", 64'(want.free_count), 64'(got.free_count));
            rsp_checked++;
        end
    endtask

    // drive at the falling edge; hold a request until taken
    always @(negedge i_clk) begin
        if (rst_cycles < 3) begin
            rst_cycles++;
            if (rst_cycles == 3) i_rst_n <= 1'b1;
        end else begin
            if (!i_req_valid || req_taken) begin
                if (pending_req_q.size() != 0 &&
                    !(pending_req_q[0].drain_first && expected_rsp_q.size() != 0) &&
                    $urandom_range(0, 99) >= pending_req_q[0].tx_idle_pct) begin
                    staged_req   = pending_req_q.pop_front();
                    i_req       <= staged_req.req;
                    i_req_valid <= 1'b1;
                    rx_stall_pct = staged_req.rx_stall_pct;
                end else begin
                    i_req_valid <= 1'b0;
                end
            end
            i_rsp_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        req_taken = 1'b0;
        if (i_rst_n) begin
            if (o_rsp_valid === 1'b1 && !i_rsp_stall) check_response(o_rsp);
            if (i_req_valid && o_req_stall === 1'b0) begin
                req_taken = 1'b1;
                expected_rsp_q.push_back(pool_apply(i_req));
            end
        end
    end

    function automatic t_req make_req(input logic [2:0] cmd, input logic [5:0] idx,
                                      input logic [63:0] host, input logic [31:0] lo,
                                      input logic [31:0] hi, input logic [63:0] handle);
        t_req r;
        r.cmd           = cmd;
        r.index         = idx;
        r.host_addr     = host;
        r.bus_addr_low  = lo;
        r.bus_addr_high = hi;
        r.free_handle   = handle;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        if ($urandom_range(0, 15) == 0) return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_host();
        logic [63:0] v;
        v = rand64();
        while (v == '0) v = rand64();
        return v;
    endfunction

    function automatic t_req rand_req(input logic [2:0] cmd, input logic [5:0] idx);
        return make_req(cmd, idx, rand64(), $urandom, $urandom, rand64());
    endfunction

    task automatic add_req(input t_req r);
        t_queued_req q;
        q.req          = r;
        q.tx_idle_pct  = gen_tx_idle;
        q.rx_stall_pct = gen_rx_stall;
        q.drain_first  = gen_drain;
        gen_drain      = 1'b0;
        pending_req_q.push_back(q);
    endtask

    function automatic logic [5:0] near_index(input int unsigned depth);
        if ($urandom_range(0, 4) == 0) return 6'($urandom_range(0, ENTRIES - 1));
        return 6'($urandom_range(0, (depth < ENTRIES) ? depth : ENTRIES - 1));
    endfunction

    initial begin
        int          i;
        int unsigned ep;
        int unsigned depth;
        int unsigned n_ops;
        int unsigned pick;
        t_req        r;

        for (i = 0; i < ENTRIES; i++) begin
            desc_host[i]   = '0;
            desc_low[i]    = '0;
            desc_high[i]   = '0;
            desc_handle[i] = '0;
            desc_busy[i]   = 1'b0;
        end

        add_req(rand_req(CMD_READ, 6'd0));
        add_req(rand_req(CMD_ALLOC, 6'd0));
        add_req(make_req(CMD_WRITE_LOW, 6'd0, '1, '1, '0, '1));
        add_req(make_req(CMD_WRITE_HIGH, 6'd0, '0, '0, '1, '0));
        add_req(rand_req(CMD_READ, 6'd0));
        add_req(make_req(CMD_WRITE_LOW, 6'd1, 64'd1, '0, '1, '0));
        add_req(make_req(CMD_WRITE_LOW, 6'd63, '1, 32'h5a5a_a5a5, '1, 64'h1));
        add_req(make_req(CMD_WRITE_HIGH, 6'd63, '1, '1, '0, '1));
        add_req(rand_req(CMD_READ, 6'd63));
        add_req(rand_req(CMD_ALLOC, 6'd63));
        add_req(rand_req(CMD_ALLOC, 6'd0));
        add_req(rand_req(CMD_ALLOC, 6'd5));
        add_req(rand_req(CMD_FREE, 6'd0));
        add_req(rand_req(CMD_FREE, 6'd0));
        add_req(rand_req(CMD_FREE, 6'd40));
        add_req(rand_req(CMD_ALLOC, 6'd0));
        add_req(make_req(CMD_WRITE_LOW, 6'd1, '0, $urandom, $urandom, rand64()));
        add_req(rand_req(CMD_RESET_ALL, 6'd1));
        add_req(make_req(CMD_WRITE_LOW, 6'd1, 64'd2, $urandom, $urandom, rand64()));
        add_req(rand_req(CMD_ALLOC, 6'd0));
        add_req(rand_req(CMD_ALLOC, 6'd0));
        add_req(rand_req(CMD_UNUSED_6, 6'd63));
        add_req(rand_req(CMD_UNUSED_7, 6'd0));
        add_req(rand_req(CMD_READ, 6'd1));

        ep = 0;
        while (pending_req_q.size() < REQ_TARGET) begin
            case (ep % 4)
                0: begin gen_tx_idle = 0;  gen_rx_stall = 0;  end
                1: begin gen_tx_idle = 85; gen_rx_stall = 0;  end
                2: begin gen_tx_idle = 0;  gen_rx_stall = 85; end
                default: begin gen_tx_idle = 10; gen_rx_stall = 10; end
            endcase
            gen_drain = (ep % 3 == 0);
            pick = $urandom_range(0, 9);
            if (pick < 7) depth = $urandom_range(1, 12);
            else if (pick < 9) depth = $urandom_range(13, 40);
            else depth = ENTRIES;
            populate_runs++;
            for (i = 0; i < depth; i++) begin
                add_req(make_req(CMD_WRITE_LOW, 6'(i), rand_host(), $urandom, $urandom,
                                 rand64()));
                if ($urandom_range(0, 1)) add_req(rand_req(CMD_WRITE_HIGH, 6'(i)));
            end
            if (depth < ENTRIES && $urandom_range(0, 4) != 0)
                add_req(make_req(CMD_WRITE_LOW, 6'(depth), '0, $urandom, $urandom,
                                 rand64()));
            n_ops = $urandom_range(20, 60);
            repeat (n_ops) begin
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    r = rand_req(CMD_ALLOC, 6'($urandom_range(0, ENTRIES - 1)));
                end else if (pick < 55) begin
                    r = rand_req(CMD_FREE, near_index(depth));
                end else if (pick < 75) begin
                    r = rand_req(CMD_READ, near_index(depth));
                end else if (pick < 83) begin
                    r = rand_req(CMD_WRITE_LOW, near_index(depth));
                    if ($urandom_range(0, 3) == 0) r.host_addr = '0;
                    else r.host_addr = rand_host();
                end else if (pick < 90) begin
                    r = rand_req(CMD_WRITE_HIGH, near_index(depth));
                end else if (pick < 95) begin
                    r = rand_req(CMD_RESET_ALL, 6'($urandom_range(0, ENTRIES - 1)));
                end else begin
                    r = rand_req(3'($urandom_range(6, 7)),
                                 6'($urandom_range(0, ENTRIES - 1)));
                end
                add_req(r);
            end
            ep++;
        end

        while (pending_req_q.size() != 0 || i_req_valid) @(posedge i_clk);
        while (expected_rsp_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Compared %0d responses; %0d allocations granted, %0d refused.",
                 rsp_checked, alloc_granted, alloc_refused);
        $display("Covered %0d populate-and-operate sequences over four idling phases.",
                 populate_runs);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d responses outstanding", expected_rsp_q.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
